// File: rtl/core/adsr_envelope_generator_assert.svh
// Assertion macros for the ADSR envelope generator RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ADSR_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adsr envelope check failed");

// Next-cycle implication, disabled during reset
`define ADSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adsr envelope check failed");

`endif

// File: rtl/core/adsr_eg_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// No dependencies; imported by the divider, the top level and the testbench.
package adsr_eg_pkg;

   // level format: unsigned, 16 fractional bits, 65536 = 1.0
   localparam int unsigned LVL_W = 17;
   localparam logic [LVL_W-1:0] FULL_SCALE = 17'h10000;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_DECAY   = 2'd1,
      CSR_RELEASE = 2'd2,
      CSR_SUSTAIN = 2'd3
   } csr_index_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/core/adsr_eg_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on adsr_eg_pkg. The quotient is known to fit LVL_W bits.
module adsr_eg_divider
   import adsr_eg_pkg::*;
#(
   parameter int unsigned LEN_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [LEN_BITS+LVL_W-1:0] num,
   input  logic [LEN_BITS-1:0]       den,
   output div_stat_type              stat,
   output logic [LVL_W-1:0]          quot
);

   localparam int unsigned CNT_W = $clog2(LVL_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LVL_W - 1);

   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [LEN_BITS-1:0] den_ff, den_in;
   logic [LVL_W-1:0]    sh_ff, sh_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [LEN_BITS:0]   trial;
   logic [LEN_BITS:0]   trial_diff;
   logic                ge;

   // trial subtract of the shifted remainder
   assign trial      = {rem_ff, sh_ff[LVL_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign ge         = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is below den since the quotient fits LVL_W bits
         rem_in  = num[LEN_BITS+LVL_W-1:LVL_W];
         sh_in   = num[LVL_W-1:0];
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial_diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
         sh_in  = {sh_ff[LVL_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = sh_ff;

endmodule

// File: rtl/core/adsr_envelope_generator.sv
// Linear ADSR envelope generator: one level sample per request beat.
// Channels: req (req_start_req, req_note_length) in, rsp (rsp_level,
// rsp_active, rsp_last) out, both valid/ready. csr writes attack, decay,
// release lengths (indexes 0..2) and the sustain level (index 3); csr_ready
// is always high and writes are expected only while the block is idle.
// A start beat latches the note length and returns sample zero; any other
// beat advances one sample. Per beat the sequencer works out the sustain
// length (start beats only), searches the phases through one shared
// subtract/compare unit, multiplies and loads, runs the bit-serial divider
// (17 quotient bits, then its done flag) and registers the result; sustain
// and off-note samples skip the multiply, load and divider. req_ready is
// high only while the sequencer is idle, so a new request beat is taken only
// after the previous one has reached the result register. The result
// register lets a new request beat enter while the previous response is
// still stalled; the sequencer then waits at its last step until rsp_ready
// frees the register.
// Reset (synchronous, active high) clears all lengths, the sustain level
// and the note state, so samples before the first start beat are 0.
// Depends on adsr_eg_pkg, adsr_eg_divider and the assertion macro header.
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator
   import adsr_eg_pkg::*;
#(
   parameter int unsigned LEN_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [((LEN_BITS > LVL_W) ? LEN_BITS : LVL_W)-1:0] csr_wdata,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_start_req,
   input  logic [LEN_BITS-1:0] req_note_length,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LVL_W-1:0]    rsp_level,
   output logic                rsp_active,
   output logic                rsp_last
);

   localparam int unsigned PROD_W = LEN_BITS + LVL_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_HOLD = 7'b0000010,
      ST_WALK = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_LOAD = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      PH_ATT,
      PH_DEC,
      PH_SUS,
      PH_REL,
      PH_OFF
   } phase_type;

   // configuration registers
   logic [LEN_BITS-1:0] attack_ff, decay_ff, release_ff;
   logic [LVL_W-1:0]    sustain_ff;

   // note state
   logic [LEN_BITS-1:0] idx_ff, idx_in;
   logic [LEN_BITS-1:0] total_ff, total_in;
   logic [LEN_BITS-1:0] hold_ff, hold_in;

   // sequencer
   state_type           state_ff, state_in;
   logic [1:0]          step_ff, step_in;
   logic [LEN_BITS-1:0] acc_ff, acc_in;
   logic                neg_ff, neg_in;
   phase_type           phase_ff, phase_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                rsp_active_ff, rsp_active_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LEN_BITS-1:0] len_sel;
   logic [LEN_BITS:0]   diff;
   logic                lt;
   logic [LVL_W-1:0]    sus_sat;
   logic [LVL_W-1:0]    mul_sel;
   logic [LEN_BITS-1:0] den_sel;
   logic                note_active;
   logic                note_last;
   logic                req_beat;
   logic                rsp_free;
   logic                div_start;
   div_stat_type        div_stat;
   logic [LVL_W-1:0]    div_quot;
   logic [LVL_W-1:0]    level_calc;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         decay_ff   <= '0;
         release_ff <= '0;
         sustain_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ATTACK:  attack_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_DECAY:   decay_ff   <= csr_wdata[LEN_BITS-1:0];
            CSR_RELEASE: release_ff <= csr_wdata[LEN_BITS-1:0];
            CSR_SUSTAIN: sustain_ff <= csr_wdata[LVL_W-1:0];
            default:     sustain_ff <= sustain_ff;
         endcase
      end
   end

   assign sus_sat = (sustain_ff > FULL_SCALE) ? FULL_SCALE : sustain_ff;

   // length operand of the shared subtract unit
   always_comb begin
      len_sel = attack_ff;
      if (state_ff == ST_HOLD) begin
         unique case (step_ff)
            2'd0:    len_sel = attack_ff;
            2'd1:    len_sel = decay_ff;
            default: len_sel = release_ff;
         endcase
      end else begin
         unique case (step_ff)
            2'd0:    len_sel = attack_ff;
            2'd1:    len_sel = decay_ff;
            2'd2:    len_sel = hold_ff;
            default: len_sel = release_ff;
         endcase
      end
   end

   // shared subtract/compare unit
   assign diff = {1'b0, acc_ff} - {1'b0, len_sel};
   assign lt   = diff[LEN_BITS];

   assign note_active = idx_ff < total_ff;
   assign note_last   = idx_ff == (total_ff - 1'b1);

   // multiplier and divisor operands by phase
   always_comb begin
      unique case (phase_ff)
         PH_ATT: begin
            mul_sel = FULL_SCALE;
            den_sel = attack_ff;
         end
         PH_DEC: begin
            mul_sel = FULL_SCALE - sus_sat;
            den_sel = decay_ff;
         end
         PH_REL: begin
            mul_sel = sus_sat;
            den_sel = release_ff;
         end
         default: begin
            mul_sel = '0;
            den_sel = release_ff;
         end
      endcase
   end

   // final level by phase: from the quotient, the sustain level, or zero
   always_comb begin
      unique case (phase_ff)
         PH_ATT:  level_calc = div_quot;
         PH_DEC:  level_calc = FULL_SCALE - div_quot;
         PH_SUS:  level_calc = sus_sat;
         PH_REL:  level_calc = sus_sat - div_quot;
         default: level_calc = '0;
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;
   assign req_beat  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign div_start = state_ff == ST_LOAD;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      phase_in      = phase_ff;
      prod_in       = prod_ff;
      idx_in        = idx_ff;
      total_in      = total_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_level_in  = rsp_level_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               step_in = 2'd0;
               if (req_start_req) begin
                  idx_in   = '0;
                  total_in = req_note_length;
                  acc_in   = req_note_length;
                  neg_in   = 1'b0;
                  state_in = ST_HOLD;
               end else begin
                  // index saturates so a finished note stays finished
                  if (idx_ff != {LEN_BITS{1'b1}}) begin
                     idx_in = idx_ff + 1'b1;
                  end
                  acc_in   = (idx_ff != {LEN_BITS{1'b1}}) ? idx_ff + 1'b1 : idx_ff;
                  state_in = ST_WALK;
               end
            end
         end

         // sustain length: note length less a, d and r, floored at zero
         ST_HOLD: begin
            if (lt) begin
               neg_in = 1'b1;
            end else begin
               acc_in = diff[LEN_BITS-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd2) begin
               hold_in  = (neg_ff || lt) ? '0 : diff[LEN_BITS-1:0];
               acc_in   = idx_ff;
               step_in  = 2'd0;
               state_in = ST_WALK;
            end
         end

         // phase search: one phase length per cycle
         ST_WALK: begin
            if (!note_active) begin
               phase_in = PH_OFF;
               state_in = ST_DONE;
            end else if (acc_ff < len_sel) begin
               unique case (step_ff)
                  2'd0:    phase_in = PH_ATT;
                  2'd1:    phase_in = PH_DEC;
                  2'd2:    phase_in = PH_SUS;
                  default: phase_in = PH_REL;
               endcase
               state_in = (step_ff == 2'd2) ? ST_DONE : ST_MUL;
            end else begin
               acc_in  = diff[LEN_BITS-1:0];
               step_in = step_ff + 1'b1;
               if (step_ff == 2'd3) begin
                  phase_in = PH_OFF;
                  state_in = ST_DONE;
               end
            end
         end

         ST_MUL: begin
            prod_in  = PROD_W'(acc_ff) * PROD_W'(mul_sel);
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            state_in = ST_DIV;
         end

         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_active_in = note_active;
               rsp_last_in   = note_active && note_last;
               rsp_level_in  = note_active ? level_calc : '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         neg_ff       <= 1'b0;
         phase_ff     <= PH_OFF;
         idx_ff       <= '0;
         total_ff     <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         neg_ff       <= neg_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   adsr_eg_divider #(
      .LEN_BITS (LEN_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (den_sel),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_level  = rsp_level_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

   // checks
   `ADSR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ADSR_ASSERT_HOLDS(a_div_start_idle, clock, reset, div_start, !div_stat.busy)
   `ADSR_ASSERT_HOLDS(a_level_range, clock, reset, rsp_valid_ff, rsp_level_ff <= FULL_SCALE)
   `ADSR_ASSERT_HOLDS(a_off_note_zero, clock, reset, rsp_valid_ff && !rsp_active_ff, rsp_level_ff == '0 && !rsp_last_ff)

endmodule

// File: tb/adsr_envelope_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for adsr_envelope_generator: directed shapes, then random notes.
// Needs only the RTL (adsr_eg_pkg and the top level); levels are predicted in-line.
module adsr_envelope_generator_test;
   import adsr_eg_pkg::*;

   localparam int LEN_W          = 24;
   localparam int CSR_W          = (LEN_W > LVL_W) ? LEN_W : LVL_W;
   localparam int ITEM_TARGET    = 1300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int LATENCY_CYCLES = 40;
   localparam int QUIET_LIMIT    = 4000;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             active;
      logic             last;
   } sample_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = CSR_ATTACK;
   logic [CSR_W-1:0]  csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_start_req = 1'b0;
   logic [LEN_W-1:0]  req_note_length = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [LVL_W-1:0]  rsp_level;
   logic              rsp_active;
   logic              rsp_last;

   // envelope settings and note state as the block should hold them
   logic [LEN_W-1:0]  model_attack = '0;
   logic [LEN_W-1:0]  model_decay = '0;
   logic [LEN_W-1:0]  model_release = '0;
   logic [LVL_W-1:0]  sustain_raw = '0;
   logic [LEN_W-1:0]  tick_pos = '0;
   logic [LEN_W-1:0]  note_span = '0;
   logic [LEN_W-1:0]  hold_span = '0;

   sample_type        expected_samples[$];
   int                fault_count = 0;
   int                beats_sent = 0;
   int                quiet_cycles = 0;
   int                stall_left = 0;
   logic              steady_flow = 1'b0;

   adsr_envelope_generator i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_req   (req_start_req),
      .req_note_length (req_note_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_level       (rsp_level),
      .rsp_active      (rsp_active),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // level of the current note at a given sample position
   function automatic logic [LVL_W-1:0] level_at_tick(logic [LEN_W-1:0] pos);
      longint unsigned p, a, d, r, h, full, s;
      p = pos;
      a = model_attack;
      d = model_decay;
      r = model_release;
      h = hold_span;
      full = FULL_SCALE;
      s = (sustain_raw > FULL_SCALE) ? full : longint'(sustain_raw);
      if (p < a) return LVL_W'((p * full) / a);
      p -= a;
      if (p < d) return LVL_W'(full - (p * (full - s)) / d);
      p -= d;
      if (p < h) return LVL_W'(s);
      p -= h;
      if (p < r) return LVL_W'(s - (p * s) / r);
      return '0;
   endfunction

   // moves the note state on by one beat and returns the sample it gives
   function automatic sample_type advance_envelope(logic start, logic [LEN_W-1:0] span);
      longint unsigned used;
      sample_type smp;
      if (start) begin
         used = longint'(model_attack) + model_decay + model_release;
         note_span = span;
         tick_pos = '0;
         hold_span = (span > used) ? LEN_W'(span - used) : '0;
      end else if (tick_pos != '1) begin
         tick_pos = tick_pos + 1'b1;
      end
      smp = '0;
      if (tick_pos < note_span) begin
         smp.active = 1'b1;
         smp.last = (tick_pos == note_span - 1'b1);
         smp.level = level_at_tick(tick_pos);
      end
      return smp;
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endtask

   // one request beat; valid stays up if the next beat follows at once
   task automatic send_beat(logic start, logic [LEN_W-1:0] span);
      int gap;
      gap = 0;
      if (!steady_flow && $urandom_range(99) < 26) gap = $urandom_range(1, 36);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_note_length <= span;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_samples.push_back(advance_envelope(start, span));
      beats_sent++;
   endtask

   // holds the sender back until every sample has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ATTACK:  model_attack = data[LEN_W-1:0];
         CSR_DECAY:   model_decay = data[LEN_W-1:0];
         CSR_RELEASE: model_release = data[LEN_W-1:0];
         CSR_SUSTAIN: sustain_raw = data[LVL_W-1:0];
         default: ;
      endcase
   endtask

   // all four registers, only once the block has gone quiet
   task automatic set_envelope(logic [LEN_W-1:0] a, logic [LEN_W-1:0] d,
                               logic [LEN_W-1:0] r, logic [LVL_W-1:0] s);
      wait_for_drain();
      write_reg(CSR_ATTACK, CSR_W'(a));
      write_reg(CSR_DECAY, CSR_W'(d));
      write_reg(CSR_RELEASE, CSR_W'(r));
      write_reg(CSR_SUSTAIN, CSR_W'(s));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [LEN_W-1:0] random_span();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return LEN_W'($urandom());
         default: return LEN_W'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic random_envelope();
      logic [LEN_W-1:0] a, d, r;
      logic [LVL_W-1:0] s;
      a = random_span();
      d = random_span();
      r = random_span();
      case ($urandom_range(5))
         0: s = '0;
         1: s = FULL_SCALE;
         2: s = LVL_W'($urandom_range(65537, 131071));
         default: s = LVL_W'($urandom_range(0, 65536));
      endcase
      set_envelope(a, d, r, s);
   endtask

   // start beat, then a run of advance beats; settings may change mid-note
   task automatic play_note(logic [LEN_W-1:0] span, int ticks);
      send_beat(1'b1, span);
      for (int t = 0; t < ticks; t++) begin
         if (!steady_flow && $urandom_range(99) < 3) random_envelope();
         send_beat(1'b0, LEN_W'($urandom()));
      end
   endtask

   task automatic test_idle_before_note();
      send_beat(1'b0, '1);
      send_beat(1'b0, '0);
   endtask

   task automatic test_phase_walk();
      // attack, decay, sustain and release in turn, then one beat past the end
      set_envelope(24'd3, 24'd2, 24'd3, 17'h08000);
      play_note(24'd11, 11);
   endtask

   task automatic test_empty_note();
      play_note(24'd0, 0);
   endtask

   task automatic test_saturated_sustain();
      // sustain register above full scale, release cut short by the note end
      set_envelope(24'd1, 24'd2, 24'd2, 17'h1FFFF);
      play_note(24'd4, 3);
   endtask

   task automatic test_extreme_lengths();
      set_envelope('1, '1, '1, FULL_SCALE);
      play_note('1, 1);
      // new settings take effect inside the running note
      set_envelope(24'd1, 24'd0, '1, 17'h01234);
      send_beat(1'b0, '0);
   endtask

   task automatic test_random_notes(int target);
      int span, ticks;
      longint unsigned used;
      while (beats_sent < target) begin
         case ($urandom_range(19))
            0, 1: random_envelope();
            2: wait_for_drain();
            3, 4: send_beat(1'($urandom_range(1)), LEN_W'($urandom()));
            default: begin
               used = longint'(model_attack) + model_decay + model_release;
               case ($urandom_range(9))
                  0: span = 0;
                  1: span = $urandom_range(0, 24'hFFFFFF);
                  default: span = $urandom_range(0, (used < 32) ? int'(used) + 6 : 40);
               endcase
               ticks = ((span > 40) ? 40 : span) + $urandom_range(0, 2);
               play_note(LEN_W'(span), ticks);
            end
         endcase
      end
   endtask

   // notes with no idling on either side and no register writes
   task automatic test_back_to_back(int count);
      int target;
      random_envelope();
      target = beats_sent + count;
      steady_flow = 1'b1;
      while (beats_sent < target)
         play_note(LEN_W'($urandom_range(0, 40)), $urandom_range(0, 42));
      steady_flow = 1'b0;
   endtask

   // receiver: short random stalls, now and then a long one
   always @(posedge clock) begin
      if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(999) < 5) begin
         stall_left <= $urandom_range(20, 60);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 12);
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_samples
      sample_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            note_fault($sformatf("sample with none expected: level=%0d active=%0b last=%0b",
                                 rsp_level, rsp_active, rsp_last));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_level !== want.level || rsp_active !== want.active ||
                rsp_last !== want.last)
               note_fault($sformatf("level %0d/%0d active %0b/%0b last %0b/%0b (exp/got)",
                                    want.level, rsp_level, want.active, rsp_active,
                                    want.last, rsp_last));
         end
      end
   end

   // cycles since any beat was accepted on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
          (csr_valid && csr_ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("[adsr_envelope_generator] ERROR");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_before_note();
      test_phase_walk();
      test_empty_note();
      test_saturated_sustain();
      test_extreme_lengths();
      test_back_to_back(150);
      test_random_notes(ITEM_TARGET);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_samples.size() == 0) begin
         $display("[adsr_envelope_generator] OK");
      end else begin
         $display("[adsr_envelope_generator] ERROR");
      end
      $finish;
   end

endmodule
